// ----- design/union_find_engine_core_assert.svh -----
// Assertion macros used by the union-find engine controller.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef UNION_FIND_ENGINE_CORE_ASSERT_SVH
`define UNION_FIND_ENGINE_CORE_ASSERT_SVH

// A condition that must hold on every clock edge out of reset.
`define UFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define UFE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/ufe_pkg.sv -----
`timescale 1ns / 1ps

package ufe_pkg;

    localparam int ELEM_W           = 12;
    localparam int COUNT_W          = 13;
    localparam int KIND_W           = 2;
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int COUNT_RESET      = 4096;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [ELEM_W-1:0]  t_elem;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_kind KIND_UNION = 2'd0;
    localparam t_kind KIND_TEST  = 2'd1;
    localparam t_kind KIND_FIND  = 2'd2;

    // Access control for one single-port table.
    typedef struct packed {
        logic en;
        logic we;
    } t_ram_ctl;

endpackage

// ----- design/ufe_ram.sv -----
`timescale 1ns / 1ps

module ufe_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     i_clk,
    input  ufe_pkg::t_ram_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    import ufe_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One port: a cycle either writes or reads, and read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ufe_ctrl.sv -----
`timescale 1ns / 1ps

module ufe_ctrl #(
    parameter int MAX_ELEMENTS = ufe_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  ufe_pkg::t_kind                  i_kind,
    input  ufe_pkg::t_elem                  i_elem_a,
    input  ufe_pkg::t_elem                  i_elem_b,
    input  logic                            i_cfg_valid,
    input  ufe_pkg::t_count                 i_cfg_count,
    output logic                            o_busy,
    output logic                            o_res_valid,
    output logic                            o_same_set,
    output ufe_pkg::t_elem                  o_root_a,
    output ufe_pkg::t_count                 o_set_count,
    output ufe_pkg::t_ram_ctl               o_par_ctl,
    output logic [$clog2(MAX_ELEMENTS)-1:0] o_par_addr,
    output ufe_pkg::t_elem                  o_par_wdata,
    input  ufe_pkg::t_elem                  i_par_rdata,
    output ufe_pkg::t_ram_ctl               o_sz_ctl,
    output logic [$clog2(MAX_ELEMENTS)-1:0] o_sz_addr,
    output ufe_pkg::t_count                 o_sz_wdata,
    input  ufe_pkg::t_count                 i_sz_rdata
);
    import ufe_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int RESET_COUNT_I = (MAX_ELEMENTS < COUNT_RESET) ? MAX_ELEMENTS : COUNT_RESET;
    localparam t_count RESET_COUNT = COUNT_W'(RESET_COUNT_I);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK_RD,
        S_WALK,
        S_CMP_CHK,
        S_CMP_WR,
        S_SZ_A,
        S_SZ_B,
        S_LINK
    } t_state;

    t_state              r_state;
    t_count              r_count;
    t_count              r_set_cnt;
    logic [ADDR_W-1:0]   r_sweep;
    t_kind               r_kind;
    t_elem               r_elem_b;
    t_elem               r_node;
    t_elem               r_walk;
    t_elem               r_root;
    t_elem               r_root_a;
    logic                r_phase_b;
    t_count              r_size_a;
    logic                r_res_valid;
    logic                r_res_same;
    t_elem               r_res_root;

    t_kind               kind_norm;
    logic                range_bad;
    t_count              cfg_clamped;
    logic                keep_a;

    always_comb begin
        kind_norm = (i_kind == KIND_UNION || i_kind == KIND_TEST) ? i_kind : KIND_FIND;
        range_bad = ({1'b0, i_elem_a} >= r_count) ||
                    (kind_norm != KIND_FIND && {1'b0, i_elem_b} >= r_count);
        if (i_cfg_count == '0) begin
            cfg_clamped = COUNT_W'(1);
        end else if (32'(i_cfg_count) > 32'(MAX_ELEMENTS)) begin
            cfg_clamped = COUNT_W'(MAX_ELEMENTS);
        end else begin
            cfg_clamped = i_cfg_count;
        end
        // Ties keep the first root on top.
        keep_a = (r_size_a >= i_sz_rdata);
    end

    // Table requests for the current step.
    always_comb begin
        o_par_ctl   = '0;
        o_par_addr  = ADDR_W'(r_node);
        o_par_wdata = r_root;
        o_sz_ctl    = '0;
        o_sz_addr   = ADDR_W'(r_root_a);
        o_sz_wdata  = COUNT_W'(1);
        case (r_state)
            S_INIT: begin
                o_par_ctl   = '{en: 1'b1, we: 1'b1};
                o_par_addr  = r_sweep;
                o_par_wdata = ELEM_W'(r_sweep);
                o_sz_ctl    = '{en: 1'b1, we: 1'b1};
                o_sz_addr   = r_sweep;
            end
            S_WALK_RD: begin
                o_par_ctl  = '{en: 1'b1, we: 1'b0};
                o_par_addr = ADDR_W'(r_node);
            end
            S_WALK: begin
                if (i_par_rdata != r_node) begin
                    o_par_ctl  = '{en: 1'b1, we: 1'b0};
                    o_par_addr = ADDR_W'(i_par_rdata);
                end
            end
            S_CMP_CHK: begin
                if (r_walk != r_root) begin
                    o_par_ctl  = '{en: 1'b1, we: 1'b0};
                    o_par_addr = ADDR_W'(r_walk);
                end
            end
            S_CMP_WR: begin
                o_par_ctl   = '{en: 1'b1, we: 1'b1};
                o_par_addr  = ADDR_W'(r_walk);
                o_par_wdata = r_root;
            end
            S_SZ_A: begin
                o_sz_ctl  = '{en: 1'b1, we: 1'b0};
                o_sz_addr = ADDR_W'(r_root_a);
            end
            S_SZ_B: begin
                o_sz_ctl  = '{en: 1'b1, we: 1'b0};
                o_sz_addr = ADDR_W'(r_root);
            end
            S_LINK: begin
                o_par_ctl   = '{en: 1'b1, we: 1'b1};
                o_par_addr  = keep_a ? ADDR_W'(r_root) : ADDR_W'(r_root_a);
                o_par_wdata = keep_a ? r_root_a : r_root;
                o_sz_ctl    = '{en: 1'b1, we: 1'b1};
                o_sz_addr   = keep_a ? ADDR_W'(r_root_a) : ADDR_W'(r_root);
                o_sz_wdata  = r_size_a + i_sz_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= RESET_COUNT;
            r_set_cnt   <= RESET_COUNT;
            r_sweep     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_count   <= cfg_clamped;
                r_set_cnt <= cfg_clamped;
                r_sweep   <= '0;
                r_state   <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_sweep <= r_sweep + 1'b1;
                        if (r_sweep == ADDR_W'(r_count - 1'b1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_start) begin
                            if (range_bad) begin
                                r_res_valid <= 1'b1;
                                r_res_same  <= 1'b0;
                                r_res_root  <= i_elem_a;
                            end else begin
                                r_kind    <= kind_norm;
                                r_elem_b  <= i_elem_b;
                                r_node    <= i_elem_a;
                                r_walk    <= i_elem_a;
                                r_phase_b <= 1'b0;
                                r_state   <= S_WALK_RD;
                            end
                        end
                    end
                    S_WALK_RD: begin
                        r_state <= S_WALK;
                    end
                    S_WALK: begin
                        if (i_par_rdata == r_node) begin
                            r_root  <= r_node;
                            r_state <= S_CMP_CHK;
                        end else begin
                            r_node <= i_par_rdata;
                        end
                    end
                    S_CMP_CHK: begin
                        if (r_walk != r_root) begin
                            r_state <= S_CMP_WR;
                        end else if (r_kind == KIND_FIND) begin
                            r_res_valid <= 1'b1;
                            r_res_same  <= 1'b0;
                            r_res_root  <= r_root;
                            r_state     <= S_IDLE;
                        end else if (!r_phase_b) begin
                            r_root_a  <= r_root;
                            r_phase_b <= 1'b1;
                            r_node    <= r_elem_b;
                            r_walk    <= r_elem_b;
                            r_state   <= S_WALK_RD;
                        end else if (r_root_a == r_root) begin
                            r_res_valid <= 1'b1;
                            r_res_same  <= 1'b1;
                            r_res_root  <= r_root_a;
                            r_state     <= S_IDLE;
                        end else if (r_kind == KIND_UNION) begin
                            r_state <= S_SZ_A;
                        end else begin
                            r_res_valid <= 1'b1;
                            r_res_same  <= 1'b0;
                            r_res_root  <= r_root_a;
                            r_state     <= S_IDLE;
                        end
                    end
                    S_CMP_WR: begin
                        r_walk  <= i_par_rdata;
                        r_state <= S_CMP_CHK;
                    end
                    S_SZ_A: begin
                        r_state <= S_SZ_B;
                    end
                    S_SZ_B: begin
                        r_size_a <= i_sz_rdata;
                        r_state  <= S_LINK;
                    end
                    S_LINK: begin
                        r_res_valid <= 1'b1;
                        r_res_same  <= 1'b0;
                        r_res_root  <= keep_a ? r_root_a : r_root;
                        if (r_set_cnt != '0) begin
                            r_set_cnt <= r_set_cnt - 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_same_set  = r_res_same;
    assign o_root_a    = r_res_root;
    assign o_set_count = r_set_cnt;

`include "union_find_engine_core_assert.svh"

    `UFE_ASSERT_ALWAYS(a_set_cnt_bound, r_set_cnt <= r_count, "set count above element count")
    `UFE_ASSERT_IMPLIES(a_walk_in_range, r_state == S_WALK, {1'b0, r_node} < r_count, "walk left the element range")
    `UFE_ASSERT_IMPLIES(a_link_distinct, r_state == S_LINK, r_root_a != r_root, "link between equal roots")
    `UFE_ASSERT_IMPLIES(a_idle_entry, r_state == S_IDLE && $past(r_state) != S_IDLE, r_res_valid || $past(r_state) == S_INIT, "returned to idle without a result")

endmodule

// ----- design/union_find_engine_core.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+---------------------------------
// command  | in        | start, busy (taken: start&!busy) | i_kind, i_elem_a, i_elem_b
// result   | out       | o_valid strobe, one cycle     | o_same_set, o_root_a, o_set_count
// config   | in        | i_cfg_valid, o_cfg_ready      | i_element_count
//
// A find walks the parent pointers from the element to its root and then
// rewrites every entry on that path to point at the root (path compression);
// the single port of the parent table serializes these reads and writes.
// Test and union run the same walk for both elements, and a union that links
// two sets adds the size table reads and the link write. An item with an
// element out of range is answered the cycle after it is taken.
// After reset and after every element count write, the block sweeps the first
// element_count entries of the tables with busy high. The result strobe cannot
// be held off by the receiver; a new item can be taken in the strobe cycle.
module union_find_engine_core #(
    parameter int MAX_ELEMENTS = ufe_pkg::MAX_ELEMENTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ufe_pkg::t_kind  i_kind,
    input  ufe_pkg::t_elem  i_elem_a,
    input  ufe_pkg::t_elem  i_elem_b,
    output logic            o_valid,
    output logic            o_same_set,
    output ufe_pkg::t_elem  o_root_a,
    output ufe_pkg::t_count o_set_count,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  ufe_pkg::t_count i_element_count
);
    import ufe_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);

    // The parent table and the size table each have one port; the
    // controller issues at most one access to each per cycle.
    t_ram_ctl          par_ctl;
    logic [ADDR_W-1:0] par_addr;
    t_elem             par_wdata;
    t_elem             par_rdata;
    t_ram_ctl          sz_ctl;
    logic [ADDR_W-1:0] sz_addr;
    t_count            sz_wdata;
    t_count            sz_rdata;

    // A configuration write is always taken; it restarts the table sweep.
    assign o_cfg_ready = 1'b1;

    ufe_ctrl #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_count (i_element_count),
        .o_busy      (busy),
        .o_res_valid (o_valid),
        .o_same_set  (o_same_set),
        .o_root_a    (o_root_a),
        .o_set_count (o_set_count),
        .o_par_ctl   (par_ctl),
        .o_par_addr  (par_addr),
        .o_par_wdata (par_wdata),
        .i_par_rdata (par_rdata),
        .o_sz_ctl    (sz_ctl),
        .o_sz_addr   (sz_addr),
        .o_sz_wdata  (sz_wdata),
        .i_sz_rdata  (sz_rdata)
    );

    // Parent table: each entry points at its parent, a root at itself.
    ufe_ram #(
        .DEPTH(MAX_ELEMENTS),
        .WIDTH(ELEM_W)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_ctl   (par_ctl),
        .i_addr  (par_addr),
        .i_wdata (par_wdata),
        .o_rdata (par_rdata)
    );

    // Size table: only the entries of current roots are meaningful.
    ufe_ram #(
        .DEPTH(MAX_ELEMENTS),
        .WIDTH(COUNT_W)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_ctl   (sz_ctl),
        .i_addr  (sz_addr),
        .i_wdata (sz_wdata),
        .o_rdata (sz_rdata)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ufe_pkg::*;

    // Self-checking bench for the union-find engine. Commands go in on the
    // start/busy handshake, answers come back on a one-cycle o_valid strobe, and
    // the element count register is written over its own valid/ready channel.
    // A scoreboard object keeps its own copy of the forest, updates it for every
    // item the block takes, and compares each answer with the oldest prediction.

    // Items of the spare kind encoding behave as a find.
    localparam t_kind KIND_SPARE = 2'd3;

    // Longest run of cycles with no handshake of any kind. The worst case is
    // the table sweep after reset or after a count write, far above one item's
    // double walk plus compression or a sender gap.
    localparam int QUIET_LIMIT = 20000;

    // Random part: three sender idling modes, three count settings in each.
    // The extremes of the register sit in the plan. Entry 7 is replaced by a
    // random count at run time.
    localparam int          SEGMENT_ITEMS = 103;
    localparam int          IDLE_PCT [3]  = '{36, 56, 0};
    localparam int unsigned SEGMENT_PLAN [9] = '{4096, 1, 40, 8191, 2, 300, 0, 64, 4096};

    class union_find_scoreboard;
        typedef struct {
            logic   same;
            t_elem  root;
            t_count sets;
        } t_answer;

        t_elem       parent_of [MAX_ELEMENTS_DEF];
        t_count      set_size [MAX_ELEMENTS_DEF];
        t_count      live_sets;
        int unsigned elem_limit;
        t_answer     pending_answers [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            load_count(COUNT_RESET);
        endfunction

        // A count write turns every element back into a root of its own.
        function void load_count(int unsigned value);
            int unsigned v;
            v = value & 32'h1FFF;
            if (v < 1)
                v = 1;
            else if (v > MAX_ELEMENTS_DEF)
                v = MAX_ELEMENTS_DEF;
            elem_limit = v;
            live_sets  = t_count'(v);
            for (int i = 0; i < MAX_ELEMENTS_DEF; i++) begin
                parent_of[i] = t_elem'(i);
                set_size[i]  = t_count'(1);
            end
        endfunction

        // Walk up to the root, then point every entry on the path at it.
        function t_elem root_of(t_elem x);
            t_elem root;
            t_elem walk;
            t_elem next;
            root = x;
            while (parent_of[root] != root)
                root = parent_of[root];
            walk = x;
            while (walk != root) begin
                next            = parent_of[walk];
                parent_of[walk] = root;
                walk            = next;
            end
            return root;
        endfunction

        function void note_item(t_kind kind, t_elem a, t_elem b);
            t_answer ans;
            logic    pair;
            t_elem   ra;
            t_elem   rb;
            pair     = (kind == KIND_UNION) || (kind == KIND_TEST);
            ans.same = 1'b0;
            ans.root = a;
            // An element beyond the count leaves the forest untouched.
            if (a < elem_limit && (!pair || b < elem_limit)) begin
                if (!pair) begin
                    ans.root = root_of(a);
                end else begin
                    ra       = root_of(a);
                    rb       = root_of(b);
                    ans.same = (ra == rb);
                    ans.root = ra;
                    if (kind == KIND_UNION && ra != rb) begin
                        // Smaller set goes under the larger; a tie keeps ra.
                        if (set_size[ra] >= set_size[rb]) begin
                            parent_of[rb] = ra;
                            set_size[ra]  = set_size[ra] + set_size[rb];
                        end else begin
                            parent_of[ra] = rb;
                            set_size[rb]  = set_size[rb] + set_size[ra];
                            ans.root      = rb;
                        end
                        if (live_sets > 0)
                            live_sets = live_sets - 1'b1;
                    end
                end
            end
            ans.sets = live_sets;
            pending_answers = {pending_answers, ans};
        endfunction

        function void check_answer(logic same, t_elem root, t_count sets);
            t_answer want;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: answer with none outstanding: same %0b root %0d sets %0d",
                             $realtime, same, root, sets);
                return;
            end
            want = pending_answers.pop_front();
            if (same !== want.same || root !== want.root || sets !== want.sets) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: answer mismatch: same %0b/%0b root %0d/%0d ",
                              "sets %0d/%0d (want/got)"},
                             $realtime, want.same, same, want.root, root,
                             want.sets, sets);
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_kind  i_kind;
    t_elem  i_elem_a;
    t_elem  i_elem_b;
    logic   o_valid;
    logic   o_same_set;
    t_elem  o_root_a;
    t_count o_set_count;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    t_count i_element_count;

    union_find_scoreboard dsu_board = new();
    int                   idle_pct;
    int                   quiet_cycles;

    union_find_engine_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_elem_a        (i_elem_a),
        .i_elem_b        (i_elem_b),
        .o_valid         (o_valid),
        .o_same_set      (o_same_set),
        .o_root_a        (o_root_a),
        .o_set_count     (o_set_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_element_count (i_element_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // All handshakes are observed here, at the rising edge, before the block's
    // flops update. An answer is checked before a newly taken item is noted,
    // since the block may take the next item in the strobe cycle of the last.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_valid)
                dsu_board.check_answer(o_same_set, o_root_a, o_set_count);
            if (start && !busy)
                dsu_board.note_item(i_kind, i_elem_a, i_elem_b);
            if (i_cfg_valid && o_cfg_ready)
                dsu_board.load_count(i_element_count);
            if (o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is
    // taken with start still high, so a following item keeps start asserted.
    task automatic send_item(t_kind kind, t_elem a, t_elem b);
        while ($urandom_range(99, 0) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start    = 1'b1;
        i_kind   = kind;
        i_elem_a = a;
        i_elem_b = b;
        @(posedge i_clk);
        while (!(start && !busy))
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The count is only written once every answer is back. Each item yields
    // exactly one answer, so an empty queue means the block is idle.
    task automatic write_count(t_count value);
        start = 1'b0;
        while (dsu_board.pending_answers.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid     = 1'b1;
        i_element_count = value;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready))
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Unions dominate so the forest grows deep enough for real compression.
    function automatic t_kind pick_kind();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return KIND_UNION;
        else if (r < 65)
            return KIND_TEST;
        else if (r < 90)
            return KIND_FIND;
        return KIND_SPARE;
    endfunction

    // Mostly elements in use; the rest may land beyond the count.
    function automatic t_elem pick_elem(int unsigned limit);
        if ($urandom_range(99, 0) < 90)
            return t_elem'($urandom_range(limit - 1, 0));
        return t_elem'($urandom_range(4095, 0));
    endfunction

    initial begin
        int unsigned value;
        int unsigned limit;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_kind          = KIND_UNION;
        i_elem_a        = '0;
        i_elem_b        = '0;
        i_cfg_valid     = 1'b0;
        i_element_count = '0;
        idle_pct        = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on the full reset count: link the two extreme
        // elements with a tie, then build a two-level tree so that a find has
        // a path to compress, and join a smaller set under a larger one.
        send_item(KIND_UNION, 12'd0, 12'd4095);
        send_item(KIND_TEST, 12'd4095, 12'd0);
        send_item(KIND_FIND, 12'd4095, 12'd0);
        send_item(KIND_SPARE, 12'd4095, 12'd4095);
        send_item(KIND_UNION, 12'd1, 12'd2);
        send_item(KIND_UNION, 12'd3, 12'd1);
        send_item(KIND_UNION, 12'd4, 12'd5);
        send_item(KIND_UNION, 12'd1, 12'd4);
        send_item(KIND_FIND, 12'd5, 12'd0);
        send_item(KIND_TEST, 12'd5, 12'd3);
        send_item(KIND_UNION, 12'd4095, 12'd3);
        send_item(KIND_FIND, 12'd4095, 12'd1);
        send_item(KIND_UNION, 12'd2, 12'd2);

        // A small count puts elements out of range; a find ignores its
        // second element even when that one is out of range.
        write_count(13'd5);
        send_item(KIND_UNION, 12'd4, 12'd5);
        send_item(KIND_TEST, 12'd0, 12'd4095);
        send_item(KIND_FIND, 12'd4095, 12'd0);
        send_item(KIND_FIND, 12'd1, 12'd4095);
        send_item(KIND_UNION, 12'd4, 12'd3);
        send_item(KIND_UNION, 12'd2, 12'd4);

        // A zero count acts as a single element.
        write_count(13'd0);
        send_item(KIND_UNION, 12'd0, 12'd0);
        send_item(KIND_TEST, 12'd0, 12'd1);
        send_item(KIND_SPARE, 12'd0, 12'd4095);

        // The largest register value saturates at the table depth.
        write_count(13'd8191);
        send_item(KIND_UNION, 12'd4095, 12'd2048);
        send_item(KIND_TEST, 12'd2048, 12'd4095);
        send_item(KIND_FIND, 12'hAAA, 12'h555);

        // Random part.
        for (int mode = 0; mode < 3; mode++) begin
            for (int seg = 0; seg < 3; seg++) begin
                value = SEGMENT_PLAN[mode * 3 + seg];
                if (mode * 3 + seg == 7)
                    value = $urandom_range(1000, 3);
                idle_pct = 0;
                write_count(t_count'(value));
                idle_pct = IDLE_PCT[mode];
                limit    = dsu_board.elem_limit;
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                    send_item(pick_kind(), pick_elem(limit), pick_elem(limit));
            end
        end

        start = 1'b0;
        while (dsu_board.pending_answers.size() != 0)
            @(posedge i_clk);
        // Catch any stray strobe after the last expected answer.
        repeat (100) @(posedge i_clk);
        if (dsu_board.mismatches == 0 && dsu_board.pending_answers.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
